@@ rtl/core/kmp_pkg.sv @@
// ----------------------------------------------------------------------------
// kmp_pkg
// Shared types and constants of the keypad matrix port unit.
// ----------------------------------------------------------------------------
package kmp_pkg;

    // Item kinds
    localparam logic [2:0] KIND_RD_P0   = 3'd0;
    localparam logic [2:0] KIND_RD_P1   = 3'd1;
    localparam logic [2:0] KIND_WR_P0   = 3'd2;
    localparam logic [2:0] KIND_WR_P1   = 3'd3;
    localparam logic [2:0] KIND_WR_DIR1 = 3'd4;
    localparam logic [2:0] KIND_WR_DIR0 = 3'd5;
    localparam logic [2:0] KIND_SET_KEY = 3'd6;

    // Key codes
    localparam logic [1:0] KEY_PRESSED = 2'd1;

    // Hotkey and direction patterns
    localparam logic [7:0] PAT_FB = 8'hFB;
    localparam logic [7:0] PAT_FD = 8'hFD;
    localparam logic [7:0] PAT_FE = 8'hFE;
    localparam logic [7:0] PAT_F0 = 8'hF0;
    localparam logic [7:0] PAT_FC = 8'hFC;
    localparam logic [7:0] PAT_FF = 8'hFF;

    localparam int NUM_ROWS   = 8;
    localparam int ROW_BITS   = 3;
    localparam int IN_WIDTH   = 24;
    localparam int OUT_WIDTH  = 32;

    typedef struct packed {
        logic                capture;
        logic                exec;
        logic                scan_step;
        logic [ROW_BITS-1:0] row;
        logic                finish;
        logic                load_out;
    } kmp_cmd_t;

    typedef struct packed {
        logic need_scan;
    } kmp_status_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_EXEC = 5'b00010,
        ST_SCAN = 5'b00100,
        ST_FIN  = 5'b01000,
        ST_DONE = 5'b10000
    } kmp_state_t;

endpackage

@@ rtl/core/kmp_ctrl.sv @@
// ----------------------------------------------------------------------------
// kmp_ctrl
// Sequencer: accepts a word, runs the operation, steps the row scan, and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module kmp_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  kmp_pkg::kmp_status_t status,
    output kmp_pkg::kmp_cmd_t   cmd
);

    kmp_pkg::kmp_state_t             state_reg, state_next;
    logic [kmp_pkg::ROW_BITS-1:0]    row_reg, row_next;
    logic                            out_valid_reg, out_valid_next;

    assign s_tready = (state_reg == kmp_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        row_next       = row_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.row        = row_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            kmp_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = kmp_pkg::ST_EXEC;
                end
            end
            kmp_pkg::ST_EXEC: begin
                cmd.exec = 1'b1;
                row_next = '0;
                state_next = status.need_scan ? kmp_pkg::ST_SCAN : kmp_pkg::ST_DONE;
            end
            kmp_pkg::ST_SCAN: begin
                cmd.scan_step = 1'b1;
                row_next      = row_reg + 1'b1;
                if (row_reg == kmp_pkg::ROW_BITS'(kmp_pkg::NUM_ROWS - 1)) begin
                    state_next = kmp_pkg::ST_FIN;
                end
            end
            kmp_pkg::ST_FIN: begin
                cmd.finish = 1'b1;
                state_next = kmp_pkg::ST_DONE;
            end
            kmp_pkg::ST_DONE: begin
                // hold until the output slot is free
                if (!out_valid_reg || m_tready) begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = kmp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = kmp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= kmp_pkg::ST_IDLE;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ rtl/core/kmp_datapath.sv @@
// ----------------------------------------------------------------------------
// kmp_datapath
// Key store, port and direction registers, line control, row scan
// accumulators and the output register.
// ----------------------------------------------------------------------------
module kmp_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [kmp_pkg::IN_WIDTH-1:0]      s_tdata,
    output logic [kmp_pkg::OUT_WIDTH-1:0]     m_tdata,
    input  kmp_pkg::kmp_cmd_t                 cmd,
    output kmp_pkg::kmp_status_t              status
);

    // bit x set when key x of the row is not exactly pressed; all ones reads as zero
    function automatic logic [7:0] row_pattern(input logic [15:0] keys);
        logic [7:0] p;
        p = '0;
        for (int x = 0; x < 8; x++) begin
            p[x] = (keys[2*x +: 2] != kmp_pkg::KEY_PRESSED);
        end
        return (p == kmp_pkg::PAT_FF) ? 8'h00 : p;
    endfunction

    logic [15:0] key_rows_reg [kmp_pkg::NUM_ROWS];

    logic [2:0]  kind_reg;
    logic [7:0]  value_reg;
    logic [2:0]  key_row_reg;
    logic [2:0]  key_col_reg;
    logic [1:0]  key_state_reg;

    logic [7:0]  p0_reg, p1_reg, dir0_reg, dir1_reg, lc_reg;
    logic [7:0]  to0_reg, to1_reg;
    logic [kmp_pkg::OUT_WIDTH-1:0] out_data_reg;

    logic [7:0]  r6, r7, b01x, b01, drv_mask, hit, to0_row;
    logic [15:0] scan_keys;
    logic        inv, inv_row, ysend, to1_bit;

    assign r6   = row_pattern(key_rows_reg[1]);
    assign r7   = row_pattern(key_rows_reg[0]);
    assign b01  = {6'b0, p0_reg[1:0]};
    assign b01x = {6'b0, ~p0_reg[1:0]};

    assign drv_mask = {{4{dir0_reg[7]}}, {2{dir0_reg[6]}}, dir0_reg[5], dir0_reg[4]};

    // one row of the scan
    assign scan_keys = key_rows_reg[cmd.row];
    assign inv       = (p1_reg == 8'h01) || (p1_reg == 8'h02);
    assign inv_row   = inv && (cmd.row[2:1] == 2'b00);
    assign ysend     = dir1_reg[cmd.row];

    always_comb begin
        for (int x = 0; x < 8; x++) begin
            if (inv_row) begin
                hit[x] = (scan_keys[2*x +: 2] != 2'd1);
            end else begin
                hit[x] = scan_keys[2*x];
            end
        end
    end

    assign to0_row = (ysend && p1_reg[cmd.row]) ? (hit & ~drv_mask) : 8'h00;
    assign to1_bit = !ysend && (|(hit & p0_reg & drv_mask));

    always_comb begin
        status.need_scan = 1'b0;
        unique case (kind_reg)
            kmp_pkg::KIND_RD_P0, kmp_pkg::KIND_RD_P1,
            kmp_pkg::KIND_WR_P0, kmp_pkg::KIND_WR_DIR1: begin
                status.need_scan = 1'b1;
            end
            kmp_pkg::KIND_WR_P1: begin
                if (value_reg == 8'h03) begin
                    status.need_scan = (dir1_reg == kmp_pkg::PAT_FC);
                end else begin
                    status.need_scan = (value_reg != 8'h00) && (value_reg != 8'h01) &&
                                       (value_reg != 8'h02) && (value_reg != kmp_pkg::PAT_FD) &&
                                       (value_reg != kmp_pkg::PAT_FE);
                end
            end
            default: begin
                status.need_scan = 1'b0;
            end
        endcase
    end

    // item capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg      <= s_tdata[2:0];
            value_reg     <= s_tdata[10:3];
            key_row_reg   <= s_tdata[13:11];
            key_col_reg   <= s_tdata[16:14];
            key_state_reg <= s_tdata[18:17];
        end
    end

    // architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < kmp_pkg::NUM_ROWS; r++) begin
                key_rows_reg[r] <= '0;
            end
            p0_reg   <= '0;
            p1_reg   <= '0;
            dir0_reg <= '0;
            dir1_reg <= '0;
            lc_reg   <= '0;
            to0_reg  <= '0;
            to1_reg  <= '0;
        end else if (cmd.exec) begin
            to0_reg <= '0;
            to1_reg <= '0;
            unique case (kind_reg)
                kmp_pkg::KIND_WR_P0: begin
                    p0_reg <= value_reg;
                    if (r6 == value_reg || value_reg == 8'h00 || r7 == kmp_pkg::PAT_FB) begin
                        lc_reg[0] <= 1'b0;
                    end else begin
                        lc_reg[0] <= 1'b1;
                    end
                end
                kmp_pkg::KIND_WR_P1: begin
                    p1_reg <= value_reg;
                    if (value_reg == 8'h00) begin
                        lc_reg <= (r7 == kmp_pkg::PAT_FD) ? (b01x & 8'hFE) : b01x;
                    end else if (value_reg == kmp_pkg::PAT_FD ||
                                 value_reg == kmp_pkg::PAT_FE) begin
                        lc_reg <= (r7 == value_reg) ? b01x : b01;
                    end else if (value_reg == 8'h03) begin
                        lc_reg <= (r7 == kmp_pkg::PAT_FB) ? b01x : b01;
                    end else if (value_reg == 8'h02) begin
                        p0_reg <= r6;
                    end else if (value_reg == 8'h01) begin
                        p0_reg <= r7;
                    end
                end
                kmp_pkg::KIND_WR_DIR1: begin
                    dir1_reg <= value_reg;
                end
                kmp_pkg::KIND_WR_DIR0: begin
                    dir0_reg <= value_reg;
                end
                kmp_pkg::KIND_SET_KEY: begin
                    key_rows_reg[key_row_reg][{key_col_reg, 1'b0} +: 2] <= key_state_reg;
                end
                default: begin
                    // reads and the unused kind change nothing here
                end
            endcase
        end else if (cmd.scan_step) begin
            to0_reg          <= to0_reg | to0_row;
            to1_reg[cmd.row] <= to1_bit;
        end else if (cmd.finish) begin
            p1_reg <= ((dir1_reg != kmp_pkg::PAT_FF) ? (p1_reg & dir1_reg) : p1_reg)
                      | to1_reg;
            p0_reg <= ((dir1_reg != kmp_pkg::PAT_F0) ? (p0_reg & drv_mask) : p0_reg)
                      | to0_reg;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_data_reg[7:0]   <= (kind_reg == kmp_pkg::KIND_RD_P0) ? p0_reg :
                                   (kind_reg == kmp_pkg::KIND_RD_P1) ? p1_reg : 8'h00;
            out_data_reg[15:8]  <= p0_reg;
            out_data_reg[23:16] <= p1_reg;
            out_data_reg[31:24] <= lc_reg;
        end
    end

    assign m_tdata = out_data_reg;

endmodule

@@ rtl/core/keypad_matrix_port_unit.sv @@
// ----------------------------------------------------------------------------
// keypad_matrix_port_unit
// Emulated 8x8 keypad matrix behind two 8-bit I/O ports with hotkey rules.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one command word per access: a port read, a port
//   or direction write, or a key update. Each accepted word yields exactly
//   one result word on the m_ channel with the read byte (zero for
//   non-reads) and the port0, port1 and line-control bytes after the access.
//   Accesses without a rescan (key updates, port0 direction writes,
//   hotkey-only port1 writes) go from the execute state straight to the
//   result; all others rescan, and the rescan walks the key store one row
//   per cycle over all eight rows before the finish step.
//   The sequencer takes a word only in its idle state and works one word
//   at a time.
//   A finished result sits in the output register; the next word is taken
//   while it waits. If the receiver still stalls when the following result
//   is ready, the sequencer holds it until the output register frees.
//   Reset (aresetn low, synchronous) clears all keys to released, all port,
//   direction and line-control bytes to zero, and drops m_tvalid.
// ----------------------------------------------------------------------------
module keypad_matrix_port_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] kind, [10:3] value, [13:11] key_row, [16:14] key_col,
    // [18:17] key_state, [23:19] zero
    input  logic [23:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] read_data, [15:8] port0_value, [23:16] port1_value,
    // [31:24] line_ctrl_value
    output logic [31:0] m_tdata
);

    kmp_pkg::kmp_cmd_t    cmd;
    kmp_pkg::kmp_status_t status;

    // sequencer: handshakes and scan row counter
    kmp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // key store, port registers, scan accumulators, output register
    kmp_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

@@ tb/keypad_matrix_port_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_matrix_port_unit_test
// Self-checking bench for the keypad matrix port unit. Port accesses and key
// updates go in on the s_ channel. Each result word on the m_ channel is
// compared field by field with a local model of the matrix, the port bytes
// and the line-control byte. The stimulus runs under three idle patterns.
// ----------------------------------------------------------------------------
module keypad_matrix_port_unit_test;

    // kind value that the block leaves without effect
    localparam logic [2:0] KIND_UNUSED  = 3'd7;
    // key codes besides the pressed one
    localparam logic [1:0] KEY_RELEASED = 2'd0;
    localparam logic [1:0] KEY_SPECIAL  = 2'd2;
    localparam logic [1:0] KEY_ODD      = 2'd3;

    localparam int RANDOM_PER_PHASE = 660;
    localparam int TAIL_CYCLES      = 20;
    localparam int CYCLE_LIMIT      = 400000;

    // one access word, first field in the highest bits, kind in the lowest
    typedef struct packed {
        logic [1:0] state;
        logic [2:0] col;
        logic [2:0] row;
        logic [7:0] value;
        logic [2:0] kind;
    } access_t;

    typedef struct packed {
        logic [7:0] line_ctrl;
        logic [7:0] port1;
        logic [7:0] port0;
        logic [7:0] read_data;
    } port_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // [2:0] kind, [10:3] value, [13:11] key_row,
                                  // [16:14] key_col, [18:17] key_state, [23:19] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // [7:0] read_data, [15:8] port0_value,
                                  // [23:16] port1_value, [31:24] line_ctrl_value

    keypad_matrix_port_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Port model: key store, port and direction bytes, line control
    // ------------------------------------------------------------------------
    logic [7:0][1:0] key_store [8] = '{default: '0};
    logic [7:0]      port0_q     = 8'h00;
    logic [7:0]      port1_q     = 8'h00;
    logic [7:0]      dir0_q      = 8'h00;
    logic [7:0]      dir1_q      = 8'h00;
    logic [7:0]      line_ctrl_q = 8'h00;

    // Bit x set when key x of the row is not exactly pressed; all ones reads
    // back as zero.
    function automatic logic [7:0] keys_not_pressed(input logic [7:0][1:0] row_keys);
        logic [7:0] pat;
        for (int x = 0; x < 8; x++)
            pat[x] = (row_keys[x] != kmp_pkg::KEY_PRESSED);
        return (pat == kmp_pkg::PAT_FF) ? 8'h00 : pat;
    endfunction

    // Drive rows and columns by direction, collect hits on the receiving side,
    // then mask the driven bytes.
    function automatic void rescan_matrix();
        logic [7:0] col_dir, p0, p1, to0, to1, col_mask, grp;
        logic       inv, hit;
        logic [1:0] k;
        col_dir = dir0_q & kmp_pkg::PAT_F0;
        p0      = port0_q;
        p1      = port1_q;
        to0     = 8'h00;
        to1     = 8'h00;
        // rows 0-1 invert their key sense while port1 selects one of them
        inv     = (p1 == 8'h01) || (p1 == 8'h02);
        for (int y = 0; y < 8; y++) begin
            for (int x = 0; x < 8; x++) begin
                k   = key_store[y][x];
                grp = (x < 2) ? (8'h10 << x) : (x < 4) ? 8'h40 : 8'h80;
                hit = (y < 2 && inv) ? (k != kmp_pkg::KEY_PRESSED)
                                     : (k != KEY_RELEASED && k != KEY_SPECIAL);
                if (hit) begin
                    if (dir1_q[y]) begin
                        if (p1[y] && (col_dir & grp) == 8'h00)
                            to0[x] = 1'b1;
                    end else if (p0[x] && (col_dir & grp) != 8'h00) begin
                        to1[y] = 1'b1;
                    end
                end
            end
        end
        if (dir1_q != kmp_pkg::PAT_FF)
            p1 = p1 & dir1_q;
        if (dir1_q != kmp_pkg::PAT_F0) begin
            col_mask = {{4{col_dir[7]}}, {2{col_dir[6]}}, col_dir[5:4]};
            p0       = p0 & col_mask;
        end
        port0_q = p0 | to0;
        port1_q = p1 | to1;
    endfunction

    function automatic void apply_port0_write(input logic [7:0] v);
        logic [7:0] r6, r7;
        r6      = keys_not_pressed(key_store[1]);
        r7      = keys_not_pressed(key_store[0]);
        port0_q = v;
        line_ctrl_q[0] = !(r6 == v || v == 8'h00 || r7 == kmp_pkg::PAT_FB);
        rescan_matrix();
    endfunction

    function automatic void apply_port1_write(input logic [7:0] v);
        logic [7:0] r6, r7, b01;
        r6      = keys_not_pressed(key_store[1]);
        r7      = keys_not_pressed(key_store[0]);
        b01     = port0_q & 8'h03;
        port1_q = v;
        if (v == 8'h00) begin
            line_ctrl_q = b01 ^ 8'h03;
            if (r7 == kmp_pkg::PAT_FD)
                line_ctrl_q[0] = 1'b0;
        end else if (v == kmp_pkg::PAT_FD || v == kmp_pkg::PAT_FE) begin
            line_ctrl_q = (r7 == v) ? (b01 ^ 8'h03) : b01;
        end else if (v == 8'h03) begin
            line_ctrl_q = (r7 == kmp_pkg::PAT_FB) ? (b01 ^ 8'h03) : b01;
            if (dir1_q == kmp_pkg::PAT_FC)
                rescan_matrix();
        end else if (v == 8'h02) begin
            port0_q = r6;
        end else if (v == 8'h01) begin
            port0_q = r7;
        end else begin
            rescan_matrix();
        end
    endfunction

    function automatic port_result_t predict_access(input access_t a);
        port_result_t r;
        r.read_data = 8'h00;
        case (a.kind)
            kmp_pkg::KIND_RD_P0: begin
                rescan_matrix();
                r.read_data = port0_q;
            end
            kmp_pkg::KIND_RD_P1: begin
                rescan_matrix();
                r.read_data = port1_q;
            end
            kmp_pkg::KIND_WR_P0:   apply_port0_write(a.value);
            kmp_pkg::KIND_WR_P1:   apply_port1_write(a.value);
            kmp_pkg::KIND_WR_DIR1: begin
                dir1_q = a.value;
                rescan_matrix();
            end
            kmp_pkg::KIND_WR_DIR0: dir0_q = a.value;
            kmp_pkg::KIND_SET_KEY: key_store[a.row][a.col] = a.state;
            default: ;
        endcase
        r.port0     = port0_q;
        r.port1     = port1_q;
        r.line_ctrl = line_ctrl_q;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus plan: pending words plus a copy of the keys they will leave
    // ------------------------------------------------------------------------
    access_t         pending_words [$];
    logic [7:0][1:0] plan_keys [8];
    int              planned_count = 0;

    function automatic void post_access(input logic [2:0] kind, input logic [7:0] value,
                                        input logic [2:0] row, input logic [2:0] col,
                                        input logic [1:0] state);
        access_t a;
        a.kind  = kind;
        a.value = value;
        a.row   = row;
        a.col   = col;
        a.state = state;
        pending_words.push_back(a);
        if (kind == kmp_pkg::KIND_SET_KEY)
            plan_keys[row][col] = state;
        if (kind != KIND_UNUSED)
            planned_count++;
    endfunction

    function automatic logic [7:0] hotkey_byte();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'h01;
            2: return 8'h02;
            3: return 8'h03;
            4: return kmp_pkg::PAT_FD;
            default: return kmp_pkg::PAT_FE;
        endcase
    endfunction

    // Clear row 0, maybe press hotkey keys and set direction FC, then hit port1 and port0 and read a port.
    function automatic void post_hotkey_sequence();
        for (int x = 0; x < 8; x++)
            if (plan_keys[0][x] == kmp_pkg::KEY_PRESSED)
                post_access(kmp_pkg::KIND_SET_KEY, 8'($urandom), 3'd0, x[2:0], KEY_RELEASED);
        if ($urandom_range(0, 3) != 0)
            post_access(kmp_pkg::KIND_SET_KEY, 8'($urandom), 3'd0,
                        3'($urandom_range(0, 2)), kmp_pkg::KEY_PRESSED);
        if ($urandom_range(0, 1) != 0)
            post_access(kmp_pkg::KIND_SET_KEY, 8'($urandom), 3'd1, 3'($urandom),
                        kmp_pkg::KEY_PRESSED);
        if ($urandom_range(0, 2) == 0)
            post_access(kmp_pkg::KIND_WR_DIR1, kmp_pkg::PAT_FC, 3'($urandom), 3'($urandom),
                        2'($urandom));
        post_access(kmp_pkg::KIND_WR_P1, hotkey_byte(), 3'($urandom), 3'($urandom),
                    2'($urandom));
        post_access(kmp_pkg::KIND_WR_P0,
                    ($urandom_range(0, 1) != 0) ? keys_not_pressed(plan_keys[1])
                                                : 8'($urandom),
                    3'($urandom), 3'($urandom), 2'($urandom));
        post_access(3'($urandom_range(0, 1)), 8'($urandom), 3'($urandom), 3'($urandom),
                    2'($urandom));
    endfunction

    function automatic void post_random_access();
        int         pick, w;
        logic [1:0] st;
        logic [7:0] v;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            post_hotkey_sequence();
        end else if (pick < 40) begin
            // favor rows 0-1 and releases so that hotkey patterns stay reachable
            w  = $urandom_range(0, 99);
            st = (w < 60) ? KEY_RELEASED : (w < 85) ? kmp_pkg::KEY_PRESSED
                          : (w < 93) ? KEY_SPECIAL : KEY_ODD;
            post_access(kmp_pkg::KIND_SET_KEY, 8'($urandom),
                        ($urandom_range(0, 1) != 0) ? 3'($urandom_range(0, 1))
                                                    : 3'($urandom_range(0, 7)),
                        3'($urandom), st);
        end else if (pick < 56) begin
            post_access(3'($urandom_range(0, 1)), 8'($urandom), 3'($urandom), 3'($urandom),
                        2'($urandom));
        end else if (pick < 70) begin
            v = ($urandom_range(0, 9) < 7) ? hotkey_byte() : 8'($urandom);
            post_access(kmp_pkg::KIND_WR_P1, v, 3'($urandom), 3'($urandom), 2'($urandom));
        end else if (pick < 80) begin
            w = $urandom_range(0, 9);
            v = (w < 4) ? keys_not_pressed(plan_keys[1]) : (w < 6) ? 8'h00 : 8'($urandom);
            post_access(kmp_pkg::KIND_WR_P0, v, 3'($urandom), 3'($urandom), 2'($urandom));
        end else if (pick < 88) begin
            case ($urandom_range(0, 3))
                0:       v = kmp_pkg::PAT_FF;
                1:       v = kmp_pkg::PAT_F0;
                2:       v = kmp_pkg::PAT_FC;
                default: v = 8'($urandom);
            endcase
            post_access(kmp_pkg::KIND_WR_DIR1, v, 3'($urandom), 3'($urandom), 2'($urandom));
        end else if (pick < 97) begin
            post_access(kmp_pkg::KIND_WR_DIR0, 8'($urandom), 3'($urandom), 3'($urandom),
                        2'($urandom));
        end else begin
            post_access(KIND_UNUSED, 8'($urandom), 3'($urandom), 3'($urandom),
                        2'($urandom));
        end
    endfunction

    // ------------------------------------------------------------------------
    // Driver: present the next pending word at the falling edge, idle and
    // stall by the current percentages
    // ------------------------------------------------------------------------
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int words_issued  = 0;
    int words_sent    = 0;

    always @(negedge aclk) begin
        if (aresetn) begin
            // advance only once every presented word has been taken
            if (words_sent == words_issued) begin
                if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_tdata  <= {5'b0, pending_words.pop_front()};
                    s_tvalid <= 1'b1;
                    words_issued++;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on each accepted word, check each result word
    // ------------------------------------------------------------------------
    port_result_t port_results_due [$];
    int reads_sent      = 0;
    int key_updates     = 0;
    int results_checked = 0;
    int bad_results     = 0;

    always @(posedge aclk) begin
        port_result_t want, got;
        access_t      a;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                a = s_tdata[18:0];
                port_results_due.push_back(predict_access(a));
                words_sent++;
                if (a.kind == kmp_pkg::KIND_RD_P0 || a.kind == kmp_pkg::KIND_RD_P1)
                    reads_sent++;
                if (a.kind == kmp_pkg::KIND_SET_KEY)
                    key_updates++;
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (port_results_due.size() == 0) begin
                    if (bad_results < 10)
                        $display("ERROR: unexpected result word %08h", m_tdata);
                    bad_results++;
                end else begin
                    want = port_results_due.pop_front();
                    results_checked++;
                    if (got.read_data != want.read_data || got.port0 != want.port0 ||
                        got.port1 != want.port1 || got.line_ctrl != want.line_ctrl) begin
                        if (bad_results < 10)
                            $display("ERROR: result %0d rd/p0/p1/lc exp %h %h %h %h got %h %h %h %h",
                                     results_checked, want.read_data, want.port0, want.port1,
                                     want.line_ctrl, got.read_data, got.port0, got.port1,
                                     got.line_ctrl);
                        bad_results++;
                    end
                end
            end
        end
    end

    // Hard stop for a hung handshake
    int cycle_count = 0;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("keypad_matrix_port_unit: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: reset, directed words, then three random phases
    // ------------------------------------------------------------------------
    task automatic drain_results();
        while (pending_words.size() != 0 || s_tvalid || port_results_due.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        for (int y = 0; y < 8; y++)
            plan_keys[y] = '0;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Phase one: sender idles rarely, receiver mostly stalls
        send_idle_pct = 14;
        recv_idle_pct = 86;
        post_access(kmp_pkg::KIND_RD_P0,   8'h00, 3'd0, 3'd0, KEY_RELEASED);
        // full row pattern: empty rows read as zero in the hotkey rules
        post_access(kmp_pkg::KIND_WR_P1,   8'h00, 3'd0, 3'd0, KEY_RELEASED);
        post_access(kmp_pkg::KIND_SET_KEY, 8'h00, 3'd0, 3'd2, kmp_pkg::KEY_PRESSED);
        post_access(kmp_pkg::KIND_WR_P1,   8'h03, 3'd0, 3'd0, KEY_RELEASED);
        post_access(kmp_pkg::KIND_WR_DIR1, kmp_pkg::PAT_FC, 3'd0, 3'd0, KEY_RELEASED);
        post_access(kmp_pkg::KIND_WR_P1,   8'h03, 3'd0, 3'd0, KEY_RELEASED);
        // key code three counts as pressed or special depending on the rule
        post_access(kmp_pkg::KIND_SET_KEY, 8'hFF, 3'd1, 3'd7, KEY_ODD);
        post_access(kmp_pkg::KIND_SET_KEY, 8'h00, 3'd7, 3'd0, KEY_SPECIAL);
        post_access(kmp_pkg::KIND_SET_KEY, 8'hFF, 3'd7, 3'd7, KEY_ODD);
        // port0 direction write stores only, no rescan
        post_access(kmp_pkg::KIND_WR_DIR0, 8'hFF, 3'd7, 3'd7, KEY_ODD);
        post_access(kmp_pkg::KIND_WR_P0,   8'hFF, 3'd0, 3'd0, KEY_RELEASED);
        post_access(kmp_pkg::KIND_RD_P1,   8'h00, 3'd0, 3'd0, KEY_RELEASED);
        // inverted key rule for rows 0-1
        post_access(kmp_pkg::KIND_WR_P1,   8'h01, 3'd0, 3'd0, KEY_RELEASED);
        post_access(kmp_pkg::KIND_RD_P0,   8'h00, 3'd0, 3'd0, KEY_RELEASED);
        post_access(kmp_pkg::KIND_WR_P1,   8'h02, 3'd0, 3'd0, KEY_RELEASED);
        post_access(kmp_pkg::KIND_RD_P1,   8'h00, 3'd0, 3'd0, KEY_RELEASED);
        post_access(kmp_pkg::KIND_WR_DIR1, kmp_pkg::PAT_F0, 3'd0, 3'd0, KEY_RELEASED);
        post_access(kmp_pkg::KIND_RD_P0,   8'h00, 3'd0, 3'd0, KEY_RELEASED);
        post_access(kmp_pkg::KIND_WR_DIR1, kmp_pkg::PAT_FF, 3'd0, 3'd0, KEY_RELEASED);
        post_access(kmp_pkg::KIND_RD_P1,   8'h00, 3'd0, 3'd0, KEY_RELEASED);
        // unused kind leaves everything alone
        post_access(KIND_UNUSED,           8'hFF, 3'd7, 3'd7, KEY_ODD);
        post_access(kmp_pkg::KIND_SET_KEY, 8'h00, 3'd0, 3'd2, KEY_RELEASED);
        post_access(kmp_pkg::KIND_SET_KEY, 8'h00, 3'd0, 3'd1, kmp_pkg::KEY_PRESSED);
        post_access(kmp_pkg::KIND_WR_P1,   kmp_pkg::PAT_FD, 3'd0, 3'd0, KEY_RELEASED);
        post_access(kmp_pkg::KIND_WR_P1,   kmp_pkg::PAT_FE, 3'd0, 3'd0, KEY_RELEASED);
        post_access(kmp_pkg::KIND_WR_P0,   8'h00, 3'd0, 3'd0, KEY_RELEASED);

        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_idle_pct = 86;
                recv_idle_pct = 14;
            end else if (phase == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            planned_count = 0;
            while (planned_count < RANDOM_PER_PHASE)
                post_random_access();
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Covered %0d accesses (%0d port reads, %0d key updates) in three idle mixes;",
                 words_sent, reads_sent, key_updates);
        $display("%0d result words checked, %0d bad.", results_checked, bad_results);
        if (bad_results == 0 && port_results_due.size() == 0)
            $display("keypad_matrix_port_unit: match");
        else
            $display("keypad_matrix_port_unit: mismatch");
        $finish;
    end

endmodule
